[design/eets_pkg.sv]
// ----------------------------------------------------------------------------
// eets_pkg
// Shared types and constants for the encoder edge timestamp sampler.
// ----------------------------------------------------------------------------
package eets_pkg;

    // Defaults for the top-level parameters
    localparam int RECORDS_PER_PACKET_DEF = 100;
    localparam int PACKET_BUFFERS_DEF     = 3;

    // Register reset values
    localparam logic [31:0] RECORD_INTERVAL_RST  = 32'd75000;
    localparam logic [31:0] WRAP_THRESHOLD_RST   = 32'd2147483647;
    localparam logic [31:0] EDGE_COUNT_LIMIT_RST = 32'h5FFF_FFFF;

    // Register indexes on the configuration port
    localparam int          CFG_IDX_W = 2;
    localparam logic [1:0]  CFG_RECORD_INTERVAL  = 2'd0;
    localparam logic [1:0]  CFG_WRAP_THRESHOLD   = 2'd1;
    localparam logic [1:0]  CFG_EDGE_COUNT_LIMIT = 2'd2;

    // Width of the internal slot and buffer arithmetic (one bit of headroom)
    localparam int SLOT_W      = 7;
    localparam int SLOT_CALC_W = SLOT_W + 1;
    localparam int BUF_W       = 2;
    localparam int BUF_CALC_W  = BUF_W + 1;

    // Result queue
    localparam int MAX_RESULTS    = 3;
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_QUAD   = 2'd1,
        KIND_READY  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [BUF_W-1:0]   buffer_number;
        logic [SLOT_W-1:0]  slot_number;
        logic [31:0]        stamp;
        logic [31:0]        wrap_count;
        logic [31:0]        edges_seen;
        logic [31:0]        edges_since_index;
        logic               quad_bit;
        logic               last;
    } t_result;

endpackage

[design/eets_result_fifo.sv]
// ----------------------------------------------------------------------------
// eets_result_fifo
// Small result queue: takes up to MAX_RESULTS results in one cycle, in order,
// and hands them out one beat per cycle while i_stall is low.
// ----------------------------------------------------------------------------
module eets_result_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [eets_pkg::MAX_RESULTS-1:0] i_push,
    input  eets_pkg::t_result   i_entry [eets_pkg::MAX_RESULTS],
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_stall,
    output eets_pkg::t_result   o_head
);
    import eets_pkg::*;

    t_result                r_mem [RES_FIFO_DEPTH];
    logic [RES_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [RES_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [RES_CNT_W-1:0]   r_count, n_count;
    logic [RES_CNT_W-1:0]   occ;
    logic [RES_CNT_W-1:0]   push_cnt;
    logic [RES_PTR_W-1:0]   w_idx [MAX_RESULTS];
    logic                   pop;

    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // occupancy once this cycle's pop has gone
    assign occ    = r_count - RES_CNT_W'(pop);
    assign o_room = (occ <= RES_CNT_W'(RES_FIFO_DEPTH - MAX_RESULTS));

    // valid results are packed into consecutive places
    always_comb begin
        logic [RES_CNT_W-1:0] off;
        off = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            w_idx[k] = r_wr_ptr + off[RES_PTR_W-1:0];
            off      = off + RES_CNT_W'(i_push[k]);
        end
        push_cnt = off;
    end

    assign n_wr_ptr = r_wr_ptr + push_cnt[RES_PTR_W-1:0];
    assign n_rd_ptr = r_rd_ptr + RES_PTR_W'(pop);
    assign n_count  = occ + push_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (i_push[k]) begin
                r_mem[w_idx[k]] <= i_entry[k];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RES_CNT_W'(RES_FIFO_DEPTH))
        else $error("result queue count above depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, occ} + {1'b0, push_cnt}) <= (RES_CNT_W+1)'(RES_FIFO_DEPTH))
        else $error("result queue overrun");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push != '0) |-> o_room)
        else $error("results pushed without room");
`endif

endmodule

[design/encoder_edge_timestamp_sampler_top.sv]
// ----------------------------------------------------------------------------
// encoder_edge_timestamp_sampler_top
// Per-tick encoder edge counter and interval-driven timestamp recorder.
// ----------------------------------------------------------------------------
// A tick is taken into an input register and processed from there once the
// result queue has room, so a tick can be accepted on every clock while
// o_stall is low. Each tick yields zero to three results (sample record,
// quadrature bit, packet ready), which go into a four-entry result queue and
// appear after passing the input register and the queue. The output side
// delivers one result per cycle while i_stall is low, so a tick is processed
// only while the queue has three free places after this cycle's output beat;
// with no output stall, ticks flow at one per cycle while ticks average at
// most one result each, a rate set by the single processing stage and queue.
module encoder_edge_timestamp_sampler_top #(
    parameter int RECORDS_PER_PACKET = eets_pkg::RECORDS_PER_PACKET_DEF,
    parameter int PACKET_BUFFERS     = eets_pkg::PACKET_BUFFERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [eets_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // tick input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_timer_value,
    input  logic        i_timer_wrapped,
    input  logic        i_encoder_level,
    input  logic        i_index_level,
    input  logic        i_quad_level,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [eets_pkg::BUF_W-1:0]  o_buffer_number,
    output logic [eets_pkg::SLOT_W-1:0] o_slot_number,
    output logic [31:0] o_stamp,
    output logic [31:0] o_wrap_count,
    output logic [31:0] o_edges_seen,
    output logic [31:0] o_edges_since_index,
    output logic        o_quad_bit,
    output logic        o_last
);
    import eets_pkg::*;

    localparam logic [SLOT_CALC_W-1:0] SLOT_LIMIT = SLOT_CALC_W'(RECORDS_PER_PACKET);
    localparam logic [BUF_CALC_W-1:0]  BUF_LIMIT  = BUF_CALC_W'(PACKET_BUFFERS);

    // configuration registers
    logic [31:0]        r_record_interval;
    logic [31:0]        r_wrap_threshold;
    logic [31:0]        r_edge_count_limit;

    // input register
    logic               r_in_valid, n_in_valid;
    logic [31:0]        r_t;
    logic               r_wrapped, r_enc, r_idx, r_quad;

    // tracking state
    logic               r_prev_enc, n_prev_enc;
    logic [31:0]        r_edge_total, n_edge_total;
    logic [31:0]        r_edge_since, n_edge_since;
    logic [31:0]        r_ovf_total, n_ovf_total;
    logic [31:0]        r_last_rec, n_last_rec;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic               r_quad_pend, n_quad_pend;

    logic               accept, proc, room;
    logic [31:0]        ovf_now, due, t_shift, edge_kept;
    logic               fire, edge_chg, quad_emit, pkt_full;
    logic [SLOT_CALC_W-1:0] slot_adv;
    logic [BUF_CALC_W-1:0]  buf_inc;

    logic [MAX_RESULTS-1:0] push;
    t_result            entry [MAX_RESULTS];
    t_result            head;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_interval  <= RECORD_INTERVAL_RST;
            r_wrap_threshold   <= WRAP_THRESHOLD_RST;
            r_edge_count_limit <= EDGE_COUNT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RECORD_INTERVAL:  r_record_interval  <= i_cfg_data;
                CFG_WRAP_THRESHOLD:   r_wrap_threshold   <= i_cfg_data;
                CFG_EDGE_COUNT_LIMIT: r_edge_count_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register handshake
    assign proc       = r_in_valid && room;
    assign o_stall    = r_in_valid && !room;
    assign accept     = i_valid && !o_stall;
    assign n_in_valid = accept || (r_in_valid && !proc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_t       <= i_timer_value;
            r_wrapped <= i_timer_wrapped;
            r_enc     <= i_encoder_level;
            r_idx     <= i_index_level;
            r_quad    <= i_quad_level;
        end
    end

    // tick processing
    always_comb begin
        ovf_now   = r_ovf_total + 32'(r_wrapped);
        due       = r_last_rec + r_record_interval;
        t_shift   = r_t + r_wrap_threshold;
        fire      = (due < r_t) || ((r_wrap_threshold < due) && (due < t_shift));
        edge_kept = (fire && (r_edge_total == r_edge_count_limit)) ? '0 : r_edge_total;
        slot_adv  = {1'b0, r_slot} + SLOT_CALC_W'(fire);
        edge_chg  = (r_enc != r_prev_enc);
        quad_emit = edge_chg && r_quad_pend;
        pkt_full  = (slot_adv >= SLOT_LIMIT);
        buf_inc   = {1'b0, r_buf} + BUF_CALC_W'(1);

        n_ovf_total  = ovf_now;
        n_last_rec   = fire ? r_t : r_last_rec;
        n_prev_enc   = r_enc;
        n_edge_total = edge_chg ? edge_kept + 32'd1 : edge_kept;
        if (!edge_chg) begin
            n_edge_since = r_edge_since;
        end else if (r_idx) begin
            n_edge_since = '0;
        end else begin
            n_edge_since = r_edge_since + 32'd1;
        end
        n_slot = pkt_full ? '0 : slot_adv[SLOT_W-1:0];
        if (!pkt_full) begin
            n_buf = r_buf;
        end else if (buf_inc >= BUF_LIMIT) begin
            n_buf = '0;
        end else begin
            n_buf = buf_inc[BUF_W-1:0];
        end
        if (pkt_full) begin
            n_quad_pend = 1'b1;
        end else if (quad_emit) begin
            n_quad_pend = 1'b0;
        end else begin
            n_quad_pend = r_quad_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_enc   <= 1'b0;
            r_edge_total <= '0;
            r_edge_since <= '0;
            r_ovf_total  <= '0;
            r_last_rec   <= '0;
            r_slot       <= '0;
            r_buf        <= '0;
            r_quad_pend  <= 1'b1;
        end else if (proc) begin
            r_prev_enc   <= n_prev_enc;
            r_edge_total <= n_edge_total;
            r_edge_since <= n_edge_since;
            r_ovf_total  <= n_ovf_total;
            r_last_rec   <= n_last_rec;
            r_slot       <= n_slot;
            r_buf        <= n_buf;
            r_quad_pend  <= n_quad_pend;
        end
    end

    // results of this tick, in output order: record, quadrature, ready
    always_comb begin
        entry[0]                   = '0;
        entry[0].kind              = KIND_RECORD;
        entry[0].buffer_number     = r_buf;
        entry[0].slot_number       = r_slot;
        entry[0].stamp             = r_t;
        entry[0].wrap_count        = ovf_now;
        entry[0].edges_seen        = r_edge_total;
        entry[0].edges_since_index = r_edge_since;
        entry[0].last              = !quad_emit && !pkt_full;

        entry[1]                   = '0;
        entry[1].kind              = KIND_QUAD;
        entry[1].buffer_number     = r_buf;
        entry[1].quad_bit          = r_quad;
        entry[1].last              = !pkt_full;

        entry[2]                   = '0;
        entry[2].kind              = KIND_READY;
        entry[2].buffer_number     = r_buf;
        entry[2].last              = 1'b1;

        push = {pkt_full, quad_emit, fire} & {MAX_RESULTS{proc}};
    end

    eets_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head)
    );

    assign o_kind              = head.kind;
    assign o_buffer_number     = head.buffer_number;
    assign o_slot_number       = head.slot_number;
    assign o_stamp             = head.stamp;
    assign o_wrap_count        = head.wrap_count;
    assign o_edges_seen        = head.edges_seen;
    assign o_edges_since_index = head.edges_since_index;
    assign o_quad_bit          = head.quad_bit;
    assign o_last              = head.last;

`ifndef NO_ASSERTIONS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_slot} < SLOT_LIMIT)
        else $error("slot index reached packet size");

    a_buf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_buf} < BUF_LIMIT)
        else $error("buffer index out of range");

    a_quad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_quad_pend && $past(r_quad_pend)) |-> $past(push[1]))
        else $error("quadrature capture cleared without a quadrature result");
`endif

endmodule

[tb/eets_result_checker.sv]
// ----------------------------------------------------------------------------
// eets_result_checker
// Watches the tick and result channels of the encoder edge timestamp sampler,
// predicts every result beat from the accepted ticks and the register writes,
// and compares each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module eets_result_checker #(
    parameter int RECORDS_PER_PACKET = eets_pkg::RECORDS_PER_PACKET_DEF,
    parameter int PACKET_BUFFERS     = eets_pkg::PACKET_BUFFERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [eets_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        tick_valid,
    input  logic        tick_stall,
    input  logic [31:0] timer_value,
    input  logic        timer_wrapped,
    input  logic        encoder_level,
    input  logic        index_level,
    input  logic        quad_level,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [1:0]  res_kind,
    input  logic [eets_pkg::BUF_W-1:0]  res_buffer_number,
    input  logic [eets_pkg::SLOT_W-1:0] res_slot_number,
    input  logic [31:0] res_stamp,
    input  logic [31:0] res_wrap_count,
    input  logic [31:0] res_edges_seen,
    input  logic [31:0] res_edges_since_index,
    input  logic        res_quad_bit,
    input  logic        res_last,
    output int          n_pending,
    output int          n_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import eets_pkg::*;

    // register copies
    logic [31:0] record_interval;
    logic [31:0] wrap_threshold;
    logic [31:0] edge_count_limit;

    // sampler state
    logic        enc_prev;
    logic [31:0] edge_total;
    logic [31:0] edges_since_ref;
    logic [31:0] overflow_total;
    logic [31:0] last_record_time;
    int          slot_idx;
    int          buf_idx;
    logic        quad_pending;

    t_result results_due[$];

    initial n_errors = 0;

    // One tick through the sampler; queues the beats it yields, last flag set on the final one
    task automatic step_sampler(input logic [31:0] tv, input logic wrapped,
                                input logic enc, input logic idx, input logic quad);
        t_result     batch[$];
        t_result     r;
        logic [31:0] sum;
        logic [31:0] tv_shifted;
        if (wrapped)
            overflow_total = overflow_total + 32'd1;

        sum        = last_record_time + record_interval;
        tv_shifted = tv + wrap_threshold;
        if ((sum < tv) || ((wrap_threshold < sum) && (sum < tv_shifted))) begin
            r                   = '0;
            r.kind              = KIND_RECORD;
            r.buffer_number     = buf_idx[BUF_W-1:0];
            r.slot_number       = slot_idx[SLOT_W-1:0];
            r.stamp             = tv;
            r.wrap_count        = overflow_total;
            r.edges_seen        = edge_total;
            r.edges_since_index = edges_since_ref;
            batch.push_back(r);
            if (edge_total == edge_count_limit)
                edge_total = '0;
            slot_idx         = slot_idx + 1;
            last_record_time = tv;
        end

        if (enc != enc_prev) begin
            enc_prev        = enc;
            edge_total      = edge_total + 32'd1;
            edges_since_ref = idx ? 32'd0 : edges_since_ref + 32'd1;
            if (quad_pending) begin
                r               = '0;
                r.kind          = KIND_QUAD;
                r.buffer_number = buf_idx[BUF_W-1:0];
                r.quad_bit      = quad;
                batch.push_back(r);
                quad_pending = 1'b0;
            end
        end

        if (slot_idx >= RECORDS_PER_PACKET) begin
            r               = '0;
            r.kind          = KIND_READY;
            r.buffer_number = buf_idx[BUF_W-1:0];
            batch.push_back(r);
            slot_idx     = 0;
            buf_idx      = (buf_idx + 1 >= PACKET_BUFFERS) ? 0 : buf_idx + 1;
            quad_pending = 1'b1;
        end

        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            results_due.push_back(batch[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors = n_errors + 1;
        end
    endtask

    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            record_interval  = RECORD_INTERVAL_RST;
            wrap_threshold   = WRAP_THRESHOLD_RST;
            edge_count_limit = EDGE_COUNT_LIMIT_RST;
            enc_prev         = 1'b0;
            edge_total       = '0;
            edges_since_ref  = '0;
            overflow_total   = '0;
            last_record_time = '0;
            slot_idx         = 0;
            buf_idx          = 0;
            quad_pending     = 1'b1;
            results_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_RECORD_INTERVAL:  record_interval  = cfg_data;
                    CFG_WRAP_THRESHOLD:   wrap_threshold   = cfg_data;
                    CFG_EDGE_COUNT_LIMIT: edge_count_limit = cfg_data;
                    default: ;  // unmapped index, dropped
                endcase
            end

            if (tick_valid && !tick_stall)
                step_sampler(timer_value, timer_wrapped, encoder_level, index_level,
                             quad_level);

            if (res_valid && !res_stall) begin
                if (results_due.size() == 0) begin
                    $error("result beat with nothing expected: kind %0d", res_kind);
                    n_errors = n_errors + 1;
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(res_kind));
                    check_field("buffer_number", 32'(want.buffer_number),
                                32'(res_buffer_number));
                    check_field("slot_number", 32'(want.slot_number),
                                32'(res_slot_number));
                    check_field("stamp", want.stamp, res_stamp);
                    check_field("wrap_count", want.wrap_count, res_wrap_count);
                    check_field("edges_seen", want.edges_seen, res_edges_seen);
                    check_field("edges_since_index", want.edges_since_index,
                                res_edges_since_index);
                    check_field("quad_bit", 32'(want.quad_bit), 32'(res_quad_bit));
                    check_field("last", 32'(want.last), 32'(res_last));
                end
            end
        end
        n_pending = results_due.size();
    end

endmodule

[tb/tb_encoder_edge_timestamp_sampler_top.sv]
// ----------------------------------------------------------------------------
// tb_encoder_edge_timestamp_sampler_top
// Stimulus for the encoder edge timestamp sampler: directed ticks around the
// record-interval comparisons, then random timer ramps and noise under several
// register settings, with random gaps on the tick side and random stalls on
// the result side. Checking is done by eets_result_checker.
// ----------------------------------------------------------------------------
module tb_encoder_edge_timestamp_sampler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eets_pkg::*;

    localparam int          RESET_CYCLES   = 8;
    localparam int          IDLE_PCT       = 24;
    localparam int          DRAIN_CYCLES   = 6;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data      = '0;
    logic        tick_valid    = 1'b0;
    logic        tick_stall;
    logic [31:0] timer_value   = '0;
    logic        timer_wrapped = 1'b0;
    logic        encoder_level = 1'b0;
    logic        index_level   = 1'b0;
    logic        quad_level    = 1'b0;
    logic        res_valid;
    logic        res_stall     = 1'b0;
    logic [1:0]  res_kind;
    logic [BUF_W-1:0]  res_buffer_number;
    logic [SLOT_W-1:0] res_slot_number;
    logic [31:0] res_stamp;
    logic [31:0] res_wrap_count;
    logic [31:0] res_edges_seen;
    logic [31:0] res_edges_since_index;
    logic        res_quad_bit;
    logic        res_last;

    int          n_pending;
    int          n_errors;
    int          idle_cycles = 0;
    bit          gaps_on     = 1'b1;
    logic [31:0] clock_now   = '0;
    logic        enc_sent    = 1'b0;
    logic [31:0] edges_sent  = '0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    encoder_edge_timestamp_sampler_top dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_valid             (tick_valid),
        .o_stall             (tick_stall),
        .i_timer_value       (timer_value),
        .i_timer_wrapped     (timer_wrapped),
        .i_encoder_level     (encoder_level),
        .i_index_level       (index_level),
        .i_quad_level        (quad_level),
        .o_valid             (res_valid),
        .i_stall             (res_stall),
        .o_kind              (res_kind),
        .o_buffer_number     (res_buffer_number),
        .o_slot_number       (res_slot_number),
        .o_stamp             (res_stamp),
        .o_wrap_count        (res_wrap_count),
        .o_edges_seen        (res_edges_seen),
        .o_edges_since_index (res_edges_since_index),
        .o_quad_bit          (res_quad_bit),
        .o_last              (res_last)
    );

    eets_result_checker checker_i (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .tick_valid            (tick_valid),
        .tick_stall            (tick_stall),
        .timer_value           (timer_value),
        .timer_wrapped         (timer_wrapped),
        .encoder_level         (encoder_level),
        .index_level           (index_level),
        .quad_level            (quad_level),
        .res_valid             (res_valid),
        .res_stall             (res_stall),
        .res_kind              (res_kind),
        .res_buffer_number     (res_buffer_number),
        .res_slot_number       (res_slot_number),
        .res_stamp             (res_stamp),
        .res_wrap_count        (res_wrap_count),
        .res_edges_seen        (res_edges_seen),
        .res_edges_since_index (res_edges_since_index),
        .res_quad_bit          (res_quad_bit),
        .res_last              (res_last),
        .n_pending             (n_pending),
        .n_errors              (n_errors)
    );

    // result side back-pressure
    always @(posedge clk) begin
        res_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // no beat on either channel for too long ends the run
    always @(posedge clk) begin
        if ((tick_valid && !tick_stall) || (res_valid && !res_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_tick(input logic [31:0] tv, input logic wrapped, input logic enc,
                             input logic idx, input logic quad);
        while (gaps_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid    <= 1'b1;
        timer_value   <= tv;
        timer_wrapped <= wrapped;
        encoder_level <= enc;
        index_level   <= idx;
        quad_level    <= quad;
        if (enc != enc_sent)
            edges_sent = edges_sent + 32'd1;
        enc_sent = enc;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
    endtask

    // drop valid, wait for every expected beat, then let ticks without results drain
    task automatic settle();
        tick_valid <= 1'b0;
        do
            @(negedge clk);
        while (n_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] interval, input logic [31:0] threshold,
                                input logic [31:0] limit, input logic [31:0] spare);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RECORD_INTERVAL;
        cfg_data  <= interval;
        @(posedge clk);
        cfg_index <= CFG_WRAP_THRESHOLD;
        cfg_data  <= threshold;
        @(posedge clk);
        cfg_index <= CFG_EDGE_COUNT_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_index <= CFG_SPARE;     // unmapped, must change nothing
        cfg_data  <= spare;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // timer ramps by a random step; a noise tick jumps to a random value
    task automatic run_ticks(input int count, input int step_lo, input int step_hi,
                             input int noise_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                clock_now = $urandom();
            else
                clock_now = clock_now + $urandom_range(step_lo, step_hi);
            send_tick(clock_now, $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        send_tick(32'd0,         1'b0, 1'b0, 1'b0, 1'b0);  // no record, no edge
        send_tick(32'd0,         1'b1, 1'b1, 1'b1, 1'b1);  // first edge on index
        send_tick(32'd75001,     1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1);
        send_tick(32'd100,       1'b0, 1'b1, 1'b0, 1'b0);  // sum wrapped low: no record
        send_tick(32'd74999,     1'b0, 1'b1, 1'b0, 1'b0);  // equal to the sum
        send_tick(32'd75000,     1'b0, 1'b0, 1'b1, 1'b0);  // one past it
        send_tick(32'h7FFF_FFF0, 1'b1, 1'b1, 1'b0, 1'b1);
        send_tick(32'h0002_0000, 1'b0, 1'b0, 1'b0, 1'b1);  // fires only through the wrap test
        send_tick(32'h0001_0000, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b1);

        // low extremes
        program_regs(32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF);
        clock_now = 32'h0010_0000;
        run_ticks(24, 0, 3, 10);

        // high extremes, fully random timer
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        run_ticks(24, 0, 0, 100);
        send_tick(32'hFFFF_FFFF, 1'b0, enc_sent, 1'b0, 1'b0);

        // a record on every tick: packets fill, buffers rotate, and the edge
        // total reaches the limit at a record so it gets cleared
        program_regs(32'd1, $urandom(), edges_sent + 32'd5, $urandom());
        clock_now = '0;
        gaps_on   = 1'b0;
        run_ticks(80, 2, 9, 0);
        gaps_on   = 1'b1;
        run_ticks(90, 2, 9, 0);

        program_regs($urandom_range(1, 8), $urandom(), $urandom_range(0, 4), $urandom());
        run_ticks(20, 0, 12, 10);

        settle();
        @(negedge clk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
